/* design/protection_entry_allocator_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the protection entry allocator
// ---------------------------------------------------------------------------
`ifndef PROTECTION_ENTRY_ALLOCATOR_DEFINES_SVH
`define PROTECTION_ENTRY_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define PEA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pea assertion failed");

// Next-cycle implication, disabled while reset is low
`define PEA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pea assertion failed");

`endif

/* design/pea_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pea_pkg
// Types and constants shared by the protection entry allocator.
// ---------------------------------------------------------------------------
package pea_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int IDX_W       = 6;
    localparam int CFG_W       = 7;
    localparam int CNT_W       = 16;
    localparam int ADDR_W      = 64;

    localparam logic [CNT_W-1:0] COUNT_TOP   = 16'hFFFF;
    localparam logic [CFG_W-1:0] ENTRIES_RST = 7'd64;

    localparam logic [1:0] STATUS_ALLOC = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_ZERO  = 2'd2;
    localparam logic [1:0] STATUS_FREED = 2'd3;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] region_base;
        logic [ADDR_W-1:0] region_size;
        logic              want_locked;
        logic [IDX_W-1:0]  entry_index;
        logic              free_is_pair;
    } pea_req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] granted_entry;
        logic             is_pair;
    } pea_rsp_t;

    // Search record handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [CNT_W-1:0] best;
        logic [IDX_W-1:0] pick;
    } pea_tok_t;

    // Entry state seen by the neighbouring cell below
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             lock;
    } pea_ent_t;

    // Controls broadcast from the sequencer to every cell
    typedef struct packed {
        logic             aligned;
        logic             locked;
        logic [CFG_W-1:0] n;
        logic             inc_en;
        logic [IDX_W-1:0] inc_idx;
        logic             inc_pair;
        logic             dec_en;
        logic [IDX_W-1:0] dec_idx;
        logic             dec_pair;
    } pea_ctl_t;

endpackage

/* design/protection_entry_allocator.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// protection_entry_allocator
// Allocates and frees memory-protection entries held in a chain of cells.
// ---------------------------------------------------------------------------
//  channel   ports                        carries
//  request   s_valid  s_ready  s_data     allocate or free request
//  result    m_valid  m_ready  m_data     status, granted entry, pair flag
//  config    cfg_valid cfg_ready cfg_data entries_in_use (always ready)
//
// An allocation result is registered after the search record has walked the
// cell chain one entry per cycle. A free or a zero-size request goes from the
// check state straight to the result state. The next request can be accepted
// in the cycle after the result is registered. Reset (synchronous, aresetn
// low) clears all counts and locks at once. A result waiting in the output
// register does not block the next request; a stalled result holds the
// sequencer before its hand-off.
// ---------------------------------------------------------------------------
`include "protection_entry_allocator_defines.svh"

module protection_entry_allocator #(
    parameter int MAX_ENTRIES = pea_pkg::ENTRIES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  pea_pkg::pea_req_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output pea_pkg::pea_rsp_t           m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pea_pkg::CFG_W-1:0]   cfg_data
);
    import pea_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    logic [1:0]       state_reg, state_next;
    pea_req_t         req_reg;
    logic             aligned_reg, aligned_next;
    pea_rsp_t         res_reg, res_next;
    logic             m_valid_reg, m_valid_next;
    pea_rsp_t         m_data_reg, m_data_next;
    logic [CFG_W-1:0] entries_reg;
    logic [CFG_W-1:0] n_eff;
    logic [ADDR_W-1:0] size_m1;
    logic             aligned_calc;
    logic             launch;
    pea_ctl_t         ctl;
    pea_tok_t         tok [0:MAX_ENTRIES];
    pea_ent_t         ent [0:MAX_ENTRIES-1];
    pea_tok_t         last_tok;

    // Configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= ENTRIES_RST;
        end else if (cfg_valid) begin
            entries_reg <= cfg_data;
        end
    end

    assign n_eff = (entries_reg > CFG_W'(MAX_ENTRIES)) ? CFG_W'(MAX_ENTRIES) : entries_reg;

    // Natural alignment check of the region
    assign size_m1      = req_reg.region_size - 1'b1;
    assign aligned_calc = ((req_reg.region_size & size_m1) == '0) &&
                          ((size_m1 & req_reg.region_base) == '0);

    assign last_tok = tok[MAX_ENTRIES];
    assign s_ready  = (state_reg == S_IDLE);

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        aligned_next = aligned_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        launch       = 1'b0;
        // the first cell judges the record while still in the check state
        ctl.aligned  = aligned_calc;
        ctl.locked   = req_reg.want_locked;
        ctl.n        = n_eff;
        ctl.inc_en   = 1'b0;
        ctl.inc_idx  = last_tok.pick;
        ctl.inc_pair = !aligned_reg;
        ctl.dec_en   = 1'b0;
        ctl.dec_idx  = req_reg.entry_index;
        ctl.dec_pair = req_reg.free_is_pair && (req_reg.entry_index != '0);

        // drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                aligned_next = aligned_calc;
                res_next     = '0;
                if (req_reg.mode) begin
                    ctl.dec_en      = 1'b1;
                    res_next.status = STATUS_FREED;
                    state_next      = S_RESP;
                end else if (req_reg.region_size == '0) begin
                    res_next.status = STATUS_ZERO;
                    state_next      = S_RESP;
                end else begin
                    launch     = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (last_tok.valid) begin
                    res_next = '0;
                    if (last_tok.found) begin
                        ctl.inc_en             = 1'b1;
                        res_next.status        = STATUS_ALLOC;
                        res_next.granted_entry = aligned_reg ? last_tok.pick
                                                             : last_tok.pick + 1'b1;
                        res_next.is_pair       = !aligned_reg;
                    end else begin
                        res_next.status = STATUS_FULL;
                    end
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        aligned_reg <= aligned_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Launch the search record into the first cell
    always_comb begin
        tok[0].valid = launch;
        tok[0].found = 1'b0;
        tok[0].best  = COUNT_TOP;
        tok[0].pick  = '0;
    end

    // Chain of entry cells
    for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
        pea_ent_t up;
        if (gi < MAX_ENTRIES - 1) begin : g_mid
            assign up = ent[gi+1];
        end else begin : g_top
            assign up = '{count: '0, lock: 1'b1};
        end
        pea_cell #(
            .CELL_IDX (gi)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .up_ent  (up),
            .tok_in  (tok[gi]),
            .tok_out (tok[gi+1]),
            .ent_out (ent[gi])
        );
    end

    // Assertions
    `PEA_ASSERT_NOW(a_tok_only_in_scan, aclk, aresetn, last_tok.valid, state_reg == S_SCAN)
    `PEA_ASSERT_NEXT(a_accept_to_check, aclk, aresetn, s_valid && s_ready, state_reg == S_CHECK)
    `PEA_ASSERT_NOW(a_pair_upper_nonzero, aclk, aresetn, m_valid && m_data.is_pair, (m_data.granted_entry != '0) && (m_data.status == STATUS_ALLOC))
    `PEA_ASSERT_NOW(a_fail_fields_clear, aclk, aresetn, m_valid && (m_data.status != STATUS_ALLOC), (m_data.granted_entry == '0) && !m_data.is_pair)

endmodule

/* design/pea_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pea_cell
// One protection entry: holds its use count and lock mark, judges the
// passing search record and hands it on to the next cell.
// ---------------------------------------------------------------------------
module pea_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pea_pkg::pea_ctl_t  ctl,
    input  pea_pkg::pea_ent_t  up_ent,
    input  pea_pkg::pea_tok_t  tok_in,
    output pea_pkg::pea_tok_t  tok_out,
    output pea_pkg::pea_ent_t  ent_out
);
    import pea_pkg::*;

    localparam logic [CFG_W-1:0] MY_IDX  = CFG_W'(CELL_IDX);
    localparam logic [CFG_W-1:0] MY_NEXT = CFG_W'(CELL_IDX + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             lock_reg, lock_next;
    logic             tok_valid_reg;
    pea_tok_t         tok_reg, tok_next;
    logic             active, last, take;
    logic [CNT_W:0]   sum;
    logic             inc_hit, dec_hit;

    // Judge this entry against the search record
    always_comb begin
        active   = (MY_IDX < ctl.n);
        last     = (MY_NEXT == ctl.n);
        sum      = {1'b0, count_reg} + (ctl.aligned ? '0 : {1'b0, up_ent.count});
        take     = 1'b0;
        tok_next = tok_in;
        if (active) begin
            if (ctl.locked) begin
                take = !tok_in.found && (count_reg == '0) &&
                       (ctl.aligned || (!last && (up_ent.count == '0)));
            end else if (!lock_reg) begin
                if (ctl.aligned || (!last && !up_ent.lock)) begin
                    take = (sum < {1'b0, tok_in.best});
                end
            end
        end
        if (take) begin
            tok_next.found = 1'b1;
            tok_next.best  = sum[CNT_W-1:0];
            tok_next.pick  = IDX_W'(CELL_IDX);
        end
    end

    // Update the entry on allocation or free
    always_comb begin
        inc_hit = ctl.inc_en && ((MY_IDX == {1'b0, ctl.inc_idx}) ||
                  (ctl.inc_pair && (MY_IDX == ({1'b0, ctl.inc_idx} + 1'b1))));
        dec_hit = ctl.dec_en && ((MY_IDX == {1'b0, ctl.dec_idx}) ||
                  (ctl.dec_pair && (MY_NEXT == {1'b0, ctl.dec_idx})));
        count_next = count_reg;
        lock_next  = lock_reg;
        priority if (inc_hit) begin
            count_next = (count_reg == COUNT_TOP) ? count_reg : count_reg + 1'b1;
            lock_next  = lock_reg | ctl.locked;
        end else if (dec_hit) begin
            count_next = (count_reg == '0) ? count_reg : count_reg - 1'b1;
            lock_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            lock_reg      <= 1'b0;
            tok_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            lock_reg      <= lock_next;
            tok_valid_reg <= tok_in.valid;
        end
    end

    // Search payload needs no reset
    always_ff @(posedge aclk) begin
        tok_reg <= tok_next;
    end

    always_comb begin
        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
        ent_out.count = count_reg;
        ent_out.lock  = lock_reg;
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the protection entry allocator: a queue-fed driver
// pushes allocate and free requests, a predictor tracks use counts and lock
// marks, and a monitor compares every result with the oldest prediction.
// The entry limit is rewritten between phases while the block is idle.
// ---------------------------------------------------------------------------
module tb_top;
    import pea_pkg::*;

    localparam int          ENTRIES     = ENTRIES_DEF;
    localparam logic        MODE_ALLOC  = 1'b0;
    localparam logic        MODE_FREE   = 1'b1;
    localparam int          PHASES      = 12;
    localparam int          PHASE_ITEMS = 167;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    pea_req_t           s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    pea_rsp_t           m_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data  = '0;

    // Predictor state
    logic [CNT_W-1:0]   entry_uses   [0:ENTRIES-1];
    logic               entry_lock_marks [0:ENTRIES-1];
    int                 active_entries = ENTRIES_RST;

    pea_req_t           pending_reqs[$];
    pea_rsp_t           expected_grants[$];
    int                 outstanding    = 0;
    int                 mismatch_count = 0;
    bit                 req_taken      = 1'b0;
    int                 send_idle      = 37;
    int                 recv_idle      = 58;

    protection_entry_allocator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Lower the count of one entry and drop its lock
    function automatic void release_entry(input int idx);
        if (idx < ENTRIES) begin
            if (entry_uses[idx] != '0) begin
                entry_uses[idx] = entry_uses[idx] - 1'b1;
            end
            entry_lock_marks[idx] = 1'b0;
        end
    endfunction

    // Work out the grant for one request and update the entry state
    function automatic pea_rsp_t predict_grant(input pea_req_t req);
        pea_rsp_t          rsp;
        logic [ADDR_W-1:0] size_m1;
        bit                aligned;
        bit                found;
        bit                last;
        int                lim;
        int                pick;
        int unsigned       best;
        int unsigned       sum;
        rsp = '0;
        if (req.mode == MODE_FREE) begin
            release_entry(int'(req.entry_index));
            if (req.free_is_pair && req.entry_index != '0) begin
                release_entry(int'(req.entry_index) - 1);
            end
            rsp.status = STATUS_FREED;
            return rsp;
        end
        if (req.region_size == '0) begin
            rsp.status = STATUS_ZERO;
            return rsp;
        end
        size_m1 = req.region_size - 1'b1;
        aligned = ((req.region_size & size_m1) == '0) && ((size_m1 & req.region_base) == '0);
        lim     = (active_entries > ENTRIES) ? ENTRIES : active_entries;
        best    = COUNT_TOP;
        found   = 1'b0;
        pick    = 0;
        for (int i = 0; i < lim; i++) begin
            last = (i + 1 == lim);
            if (req.want_locked) begin
                // lowest free entry or free pair wins
                if (!found && entry_uses[i] == '0 &&
                    (aligned || (!last && entry_uses[i+1] == '0))) begin
                    pick  = i;
                    found = 1'b1;
                end
            end else if (!entry_lock_marks[i] &&
                         (aligned || (!last && !entry_lock_marks[i+1]))) begin
                // least used candidate, lowest index on a tie
                sum = 32'(entry_uses[i]) + (aligned ? 32'd0 : 32'(entry_uses[i+1]));
                if (sum < best) begin
                    best  = sum;
                    pick  = i;
                    found = 1'b1;
                end
            end
        end
        if (!found) begin
            rsp.status = STATUS_FULL;
            return rsp;
        end
        for (int j = 0; j < (aligned ? 1 : 2); j++) begin
            if (entry_uses[pick+j] != COUNT_TOP) begin
                entry_uses[pick+j] = entry_uses[pick+j] + 1'b1;
            end
            if (req.want_locked) begin
                entry_lock_marks[pick+j] = 1'b1;
            end
        end
        rsp.status        = STATUS_ALLOC;
        rsp.granted_entry = IDX_W'(aligned ? pick : pick + 1);
        rsp.is_pair       = !aligned;
        return rsp;
    endfunction

    function automatic pea_req_t build_req(input logic mode, input logic [ADDR_W-1:0] base,
                                           input logic [ADDR_W-1:0] size, input logic locked,
                                           input logic [IDX_W-1:0] idx, input logic pair);
        pea_req_t req;
        req.mode         = mode;
        req.region_base  = base;
        req.region_size  = size;
        req.want_locked  = locked;
        req.entry_index  = idx;
        req.free_is_pair = pair;
        return req;
    endfunction

    // Hold until every queued request has produced its result
    task automatic drain_requests();
        @(posedge aclk);
        while (outstanding != 0) begin
            @(posedge aclk);
        end
    endtask

    // Driver: record accepted requests and predict their results
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_grants.push_back(predict_grant(s_data));
            req_taken = 1'b1;
        end
    end

    // Driver: present the next request, or idle
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            req_taken = 1'b0;
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                s_data  <= pending_reqs.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: stall the result channel at random
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(0, 99) >= recv_idle);
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge aclk) begin : check_grant
        pea_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_grants.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: status %0d entry %0d pair %0d",
                             m_data.status, m_data.granted_entry, m_data.is_pair);
                end
            end else begin
                want = expected_grants.pop_front();
                outstanding--;
                if (m_data.status !== want.status || m_data.granted_entry !== want.granted_entry ||
                    m_data.is_pair !== want.is_pair) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected status %0d entry %0d pair %0d, got %0d %0d %0d",
                                 want.status, want.granted_entry, want.is_pair,
                                 m_data.status, m_data.granted_entry, m_data.is_pair);
                    end
                end
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        logic [CFG_W-1:0]  limits [0:PHASES-1];
        pea_req_t          req;
        int                sel;
        int                lim;
        int                k;
        limits = '{7'd1, 7'd2, 7'd3, 7'd5, 7'd64, 7'd8, 7'd0, 7'd127, 7'd16, 7'd4, 7'd64, 7'd6};
        for (int i = 0; i < ENTRIES; i++) begin
            entry_uses[i]       = '0;
            entry_lock_marks[i] = 1'b0;
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests at the reset entry limit
        pending_reqs.push_back(build_req(MODE_ALLOC, 64'h0, 64'h0, 1'b0, 6'd0, 1'b0));
        pending_reqs.push_back(build_req(MODE_ALLOC, 64'h0, 64'h1, 1'b0, 6'd63, 1'b1));
        pending_reqs.push_back(build_req(MODE_ALLOC, '1, '1, 1'b0, 6'd0, 1'b0));
        pending_reqs.push_back(build_req(MODE_ALLOC, 64'h8000_0000_0000_0000,
                                         64'h8000_0000_0000_0000, 1'b1, 6'd0, 1'b0));
        pending_reqs.push_back(build_req(MODE_ALLOC, 64'h3, 64'h5, 1'b1, 6'd0, 1'b0));
        pending_reqs.push_back(build_req(MODE_ALLOC, 64'h1000, 64'h1000, 1'b0, 6'd0, 1'b0));
        pending_reqs.push_back(build_req(MODE_ALLOC, 64'h0, 64'h3000, 1'b0, 6'd0, 1'b0));
        pending_reqs.push_back(build_req(MODE_ALLOC, 64'h4, 64'h8, 1'b1, 6'd0, 1'b0));
        pending_reqs.push_back(build_req(MODE_ALLOC, 64'h1, 64'h1, 1'b0, 6'd0, 1'b0));
        pending_reqs.push_back(build_req(MODE_ALLOC, 64'h0, '1, 1'b1, 6'd0, 1'b0));
        pending_reqs.push_back(build_req(MODE_ALLOC, 64'h2, 64'h2, 1'b1, 6'd0, 1'b0));
        pending_reqs.push_back(build_req(MODE_FREE, '1, '1, 1'b1, 6'd0, 1'b1));
        pending_reqs.push_back(build_req(MODE_FREE, 64'h0, 64'h0, 1'b0, 6'd63, 1'b1));
        pending_reqs.push_back(build_req(MODE_FREE, 64'h0, 64'h0, 1'b0, 6'd5, 1'b0));
        pending_reqs.push_back(build_req(MODE_FREE, 64'h0, 64'h0, 1'b0, 6'd2, 1'b1));
        pending_reqs.push_back(build_req(MODE_FREE, 64'h0, 64'h0, 1'b1, 6'd20, 1'b0));
        pending_reqs.push_back(build_req(MODE_ALLOC, 64'h0, 64'h2, 1'b1, 6'd0, 1'b0));
        pending_reqs.push_back(build_req(MODE_ALLOC, 64'h3, 64'h5, 1'b0, 6'd0, 1'b0));
        pending_reqs.push_back(build_req(MODE_FREE, 64'h0, 64'h0, 1'b0, 6'd1, 1'b1));
        outstanding += pending_reqs.size();
        drain_requests();

        for (int p = 0; p < PHASES; p++) begin
            // idling profile moves on every third of the run
            case ((p * 3) / PHASES)
                0: begin
                    send_idle = 37;
                    recv_idle = 58;
                end
                1: begin
                    send_idle = 58;
                    recv_idle = 37;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase

            // Write the entry limit while the block is idle
            @(negedge aclk);
            cfg_valid <= 1'b1;
            cfg_data  <= limits[p];
            @(posedge aclk);
            while (!cfg_ready) begin
                @(posedge aclk);
            end
            active_entries = int'(limits[p]);
            @(negedge aclk);
            cfg_valid <= 1'b0;

            lim = (active_entries > ENTRIES) ? ENTRIES : active_entries;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                req = build_req(($urandom_range(0, 99) < 55) ? MODE_ALLOC : MODE_FREE,
                                {$urandom, $urandom}, {$urandom, $urandom},
                                $urandom_range(0, 99) < 40, IDX_W'($urandom), 1'($urandom));
                if (req.mode == MODE_ALLOC) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 4) begin
                        req.region_size = '0;
                    end else if (sel < 50) begin
                        // naturally aligned region, mostly small
                        k = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 12)
                                                         : $urandom_range(0, 63);
                        req.region_size = 64'd1 << k;
                        req.region_base = req.region_base & ~(req.region_size - 1'b1);
                    end else if (sel < 85) begin
                        req.region_size = 64'($urandom_range(1, 5000));
                        req.region_base = 64'($urandom_range(0, 65535));
                    end
                end else if ($urandom_range(0, 99) < 80) begin
                    req.entry_index = IDX_W'($urandom_range(0, (lim > 1) ? lim - 1 : 0));
                end
                pending_reqs.push_back(req);
            end
            outstanding += PHASE_ITEMS;
            drain_requests();
        end

        // Allow any stray result to show up
        repeat (ENTRIES + 8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #10ms;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/pea_pkg.sv
design/pea_cell.sv
design/protection_entry_allocator.sv
tb/sv/tb_top.sv
